@@ sv/rwla_pkg.sv @@
// Package for the reader/writer lock arbiter: payload structs, codes and sizes.
// No dependencies; every other file of the block refers to it by scoped names.
package rwla_pkg;

    localparam int ID_WIDTH           = 8;
    localparam int READER_QUEUE_DEPTH = 16;
    localparam int WRITER_QUEUE_DEPTH = 16;

    // Queue address and count widths
    localparam int RQ_AW = (READER_QUEUE_DEPTH > 1) ? $clog2(READER_QUEUE_DEPTH) : 1;
    localparam int RQ_CW = $clog2(READER_QUEUE_DEPTH + 1);
    localparam int WQ_AW = (WRITER_QUEUE_DEPTH > 1) ? $clog2(WRITER_QUEUE_DEPTH) : 1;
    localparam int WQ_CW = $clog2(WRITER_QUEUE_DEPTH + 1);

    // Command queue between front and back
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam logic [7:0] LIMIT_RESET = 8'd4;
    localparam logic [7:0] CNT_MAX     = 8'hFF;

    localparam logic [1:0] OP_RACQ = 2'd0;
    localparam logic [1:0] OP_RREL = 2'd1;
    localparam logic [1:0] OP_WACQ = 2'd2;
    localparam logic [1:0] OP_WREL = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_QUEUED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_REL  = 2'd3;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] requester_id;
    } cmd_t;

    typedef struct packed {
        logic       grant_valid;
        logic       grant_kind;
        logic [7:0] grant_id;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Classified request as it sits in the command queue
    typedef struct packed {
        logic                is_read;
        logic                is_release;
        logic [ID_WIDTH-1:0] id;
    } item_t;

endpackage

@@ sv/rwla_front.sv @@
// Front end of the lock arbiter: takes commands, classifies them and queues them.
// Depends on rwla_pkg.
module rwla_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rwla_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 item_valid,
    output rwla_pkg::item_t      item,
    input  logic                 item_pop
);

    rwla_pkg::item_t                 fq_reg [rwla_pkg::FQ_DEPTH];
    logic [rwla_pkg::FQ_AW-1:0]      wr_ptr_reg;
    logic [rwla_pkg::FQ_AW-1:0]      rd_ptr_reg;
    logic [rwla_pkg::FQ_CW-1:0]      count_reg;
    logic [rwla_pkg::FQ_CW-1:0]      count_next;
    rwla_pkg::item_t                 cls;
    logic                            push;

    assign busy       = (count_reg == rwla_pkg::FQ_CW'(rwla_pkg::FQ_DEPTH));
    assign push       = start && !busy;
    assign item_valid = (count_reg != '0);
    assign item       = fq_reg[rd_ptr_reg];

    always_comb
    begin
        cls.is_read    = (cmd.operation == rwla_pkg::OP_RACQ) ||
                         (cmd.operation == rwla_pkg::OP_RREL);
        cls.is_release = (cmd.operation == rwla_pkg::OP_RREL) ||
                         (cmd.operation == rwla_pkg::OP_WREL);
        cls.id         = cmd.requester_id[rwla_pkg::ID_WIDTH-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !(item_pop && item_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && item_pop && item_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == rwla_pkg::FQ_AW'(rwla_pkg::FQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (item_pop && item_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == rwla_pkg::FQ_AW'(rwla_pkg::FQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ sv/rwla_back.sv @@
// Back end of the lock arbiter: lock state, wait queues and the grant sequencer.
// Depends on rwla_pkg; fed by rwla_front through the command queue.
module rwla_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  rwla_pkg::item_t      item,
    output logic                 item_pop,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    output logic                 result_valid,
    output rwla_pkg::result_t    result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_BATCH
    } state_t;

    localparam int WSW = rwla_pkg::WQ_AW + 1;

    state_t                              state_reg, state_next;
    rwla_pkg::item_t                     cur_reg, cur_next;
    logic [7:0]                          ar_reg, ar_next;
    logic                                wa_reg, wa_next;
    logic [rwla_pkg::RQ_CW-1:0]          wrc_reg, wrc_next;
    logic [rwla_pkg::WQ_CW-1:0]          wwc_reg, wwc_next;
    logic [rwla_pkg::WQ_AW-1:0]          head_reg, head_next;
    logic [7:0]                          cwc_reg, cwc_next;
    logic [7:0]                          limit_reg;
    logic [rwla_pkg::RQ_AW-1:0]          bidx_reg, bidx_next;
    logic [rwla_pkg::RQ_CW-1:0]          blen_reg, blen_next;
    logic                                res_valid_reg, res_valid_next;
    rwla_pkg::result_t                   res_reg, res_next;

    logic [rwla_pkg::ID_WIDTH-1:0]       rq_mem [rwla_pkg::READER_QUEUE_DEPTH];
    logic [rwla_pkg::ID_WIDTH-1:0]       wq_mem [rwla_pkg::WRITER_QUEUE_DEPTH];
    logic [rwla_pkg::ID_WIDTH-1:0]       rq_rd_reg;
    logic [rwla_pkg::ID_WIDTH-1:0]       wq_rd_reg;
    logic                                rq_we;
    logic                                wq_we;
    logic [rwla_pkg::WQ_AW-1:0]          wq_tail;
    logic [WSW-1:0]                      tail_sum;
    logic [rwla_pkg::WQ_AW-1:0]          head_inc;
    logic [7:0]                          wgrant_cwc;
    logic [8:0]                          batch_sum;
    logic [7:0]                          batch_ar;
    logic                                batch_last;

    assign item_pop     = (state_reg == S_IDLE) && item_valid;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Shared terms of the decision step
    always_comb
    begin
        tail_sum = WSW'(head_reg) + WSW'(wwc_reg);
        if (tail_sum >= WSW'(rwla_pkg::WRITER_QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - WSW'(rwla_pkg::WRITER_QUEUE_DEPTH);
        end
        wq_tail  = tail_sum[rwla_pkg::WQ_AW-1:0];
        head_inc = (head_reg == rwla_pkg::WQ_AW'(rwla_pkg::WRITER_QUEUE_DEPTH - 1)) ?
                   '0 : head_reg + 1'b1;
        if (wrc_reg != '0)
        begin
            wgrant_cwc = (cwc_reg == rwla_pkg::CNT_MAX) ? cwc_reg : cwc_reg + 1'b1;
        end
        else
        begin
            wgrant_cwc = '0;
        end
        // Reader release only starts a batch once the count hits zero
        if (!cur_reg.is_read)
        begin
            batch_sum = {1'b0, ar_reg} + 9'(wrc_reg);
        end
        else
        begin
            batch_sum = 9'(wrc_reg);
        end
        batch_ar   = batch_sum[8] ? rwla_pkg::CNT_MAX : batch_sum[7:0];
        batch_last = (rwla_pkg::RQ_CW'(bidx_reg) == blen_reg - 1'b1);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ar_next        = ar_reg;
        wa_next        = wa_reg;
        wrc_next       = wrc_reg;
        wwc_next       = wwc_reg;
        head_next      = head_reg;
        cwc_next       = cwc_reg;
        bidx_next      = bidx_reg;
        blen_next      = blen_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        rq_we          = 1'b0;
        wq_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                bidx_next = '0;
                if (item_valid)
                begin
                    cur_next   = item;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next           = S_IDLE;
                res_valid_next       = 1'b1;
                res_next.grant_valid = 1'b0;
                res_next.grant_kind  = rwla_pkg::KIND_READ;
                res_next.grant_id    = '0;
                res_next.status      = rwla_pkg::ST_DONE;
                res_next.last        = 1'b1;

                if (!cur_reg.is_release)
                begin
                    if (cur_reg.is_read)
                    begin
                        if (!wa_reg && wwc_reg == '0)
                        begin
                            if (ar_reg != rwla_pkg::CNT_MAX)
                            begin
                                ar_next              = ar_reg + 1'b1;
                                res_next.grant_valid = 1'b1;
                                res_next.grant_id    = 8'(cur_reg.id);
                            end
                            else
                            begin
                                res_next.status = rwla_pkg::ST_FULL;
                            end
                        end
                        else if (wrc_reg < rwla_pkg::RQ_CW'(rwla_pkg::READER_QUEUE_DEPTH))
                        begin
                            rq_we           = 1'b1;
                            wrc_next        = wrc_reg + 1'b1;
                            res_next.status = rwla_pkg::ST_QUEUED;
                        end
                        else
                        begin
                            res_next.status = rwla_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        if (ar_reg == '0 && !wa_reg && wwc_reg == '0)
                        begin
                            wa_next              = 1'b1;
                            cwc_next             = wgrant_cwc;
                            res_next.grant_valid = 1'b1;
                            res_next.grant_kind  = rwla_pkg::KIND_WRITE;
                            res_next.grant_id    = 8'(cur_reg.id);
                        end
                        else if (wwc_reg < rwla_pkg::WQ_CW'(rwla_pkg::WRITER_QUEUE_DEPTH))
                        begin
                            wq_we           = 1'b1;
                            wwc_next        = wwc_reg + 1'b1;
                            res_next.status = rwla_pkg::ST_QUEUED;
                        end
                        else
                        begin
                            res_next.status = rwla_pkg::ST_FULL;
                        end
                    end
                end
                else
                begin
                    logic do_batch;
                    logic do_writer;
                    do_batch  = 1'b0;
                    do_writer = 1'b0;
                    if (cur_reg.is_read)
                    begin
                        if (ar_reg == '0)
                        begin
                            res_next.status = rwla_pkg::ST_BAD_REL;
                        end
                        else
                        begin
                            ar_next = ar_reg - 1'b1;
                            if (ar_reg == 8'd1 && !wa_reg)
                            begin
                                do_writer = (wwc_reg != '0);
                                do_batch  = (wwc_reg == '0) && (wrc_reg != '0);
                            end
                        end
                    end
                    else
                    begin
                        if (!wa_reg)
                        begin
                            res_next.status = rwla_pkg::ST_BAD_REL;
                        end
                        else
                        begin
                            wa_next = 1'b0;
                            if (wrc_reg != '0 && (cwc_reg >= limit_reg || wwc_reg == '0))
                            begin
                                do_batch = 1'b1;
                            end
                            else if (wwc_reg != '0)
                            begin
                                do_writer = 1'b1;
                            end
                            else
                            begin
                                cwc_next = '0;
                            end
                        end
                    end

                    if (do_writer)
                    begin
                        head_next            = head_inc;
                        wwc_next             = wwc_reg - 1'b1;
                        wa_next              = 1'b1;
                        cwc_next             = wgrant_cwc;
                        res_next.grant_valid = 1'b1;
                        res_next.grant_kind  = rwla_pkg::KIND_WRITE;
                        res_next.grant_id    = 8'(wq_rd_reg);
                    end
                    else if (do_batch)
                    begin
                        // Hand the queued readers out one per cycle
                        res_valid_next = 1'b0;
                        ar_next        = batch_ar;
                        blen_next      = wrc_reg;
                        wrc_next       = '0;
                        cwc_next       = '0;
                        bidx_next      = '0;
                        state_next     = S_BATCH;
                    end
                end
            end

            S_BATCH:
            begin
                res_valid_next       = 1'b1;
                res_next.grant_valid = 1'b1;
                res_next.grant_kind  = rwla_pkg::KIND_READ;
                res_next.grant_id    = 8'(rq_rd_reg);
                res_next.status      = rwla_pkg::ST_DONE;
                res_next.last        = batch_last;
                if (batch_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            ar_reg        <= '0;
            wa_reg        <= 1'b0;
            wrc_reg       <= '0;
            wwc_reg       <= '0;
            head_reg      <= '0;
            cwc_reg       <= '0;
            limit_reg     <= rwla_pkg::LIMIT_RESET;
            bidx_reg      <= '0;
            blen_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            ar_reg        <= ar_next;
            wa_reg        <= wa_next;
            wrc_reg       <= wrc_next;
            wwc_reg       <= wwc_next;
            head_reg      <= head_next;
            cwc_reg       <= cwc_next;
            bidx_reg      <= bidx_next;
            blen_reg      <= blen_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Wait queues; read data is registered and follows the head / batch index
    always_ff @(posedge clk)
    begin
        if (rq_we)
        begin
            rq_mem[wrc_reg[rwla_pkg::RQ_AW-1:0]] <= cur_reg.id;
        end
        rq_rd_reg <= rq_mem[bidx_next];
    end

    always_ff @(posedge clk)
    begin
        if (wq_we)
        begin
            wq_mem[wq_tail] <= cur_reg.id;
        end
        wq_rd_reg <= wq_mem[head_reg];
    end

endmodule

@@ sv/reader_writer_lock_arbiter.sv @@
// Top level of the reader/writer lock arbiter: front end, command queue, back end.
// Depends on rwla_pkg, rwla_front and rwla_back.
//
// Usage:
//   Commands: drive cmd and raise start; the command transfers at a clock edge
//   where start is high and busy is low. busy rises only when the two-entry
//   command queue is full.
//   Results: each result is on result for one cycle with result_valid high.
//   Every command gives one or more results; the final one has last set.
//   Configuration: cfg_data (writer batch limit) transfers when cfg_valid and
//   cfg_ready are high; write it only while no command is outstanding.
// Sequence:
//   The back end pops a command in S_IDLE, decides in the next cycle and shows
//   the result from a register in the cycle after that. It pops no new command
//   until it is back in S_IDLE. A release that admits queued readers first
//   starts the batch, then gives one grant per cycle from the reader queue
//   memory.
// Reset:
//   rst_n clears lock state, counters and the command queue, and sets the
//   batch limit to 4; queue contents are not cleared. The receiver cannot
//   stall, so results never wait.
module reader_writer_lock_arbiter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rwla_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 result_valid,
    output rwla_pkg::result_t    result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    logic                item_valid;
    logic                item_pop;
    rwla_pkg::item_t     item;

    assign cfg_ready = 1'b1;

    rwla_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rwla_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ sv/rwla_checker.sv @@
// Port-level checks for the reader/writer lock arbiter, bound to the top level.
// Depends on rwla_pkg and reader_writer_lock_arbiter.
module rwla_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 result_valid,
    input  rwla_pkg::result_t    result
);

    // No result strobe while in reset
    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result strobe during reset");

    // A result without a grant carries no id and no kind
    a_no_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.grant_valid |->
            result.grant_id == 8'd0 && result.grant_kind == rwla_pkg::KIND_READ)
        else $error("grant fields set on a result without grant");

    // Any non-done status and any write grant end the command's results
    a_single_results: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != rwla_pkg::ST_DONE ||
                         (result.grant_valid && result.grant_kind == rwla_pkg::KIND_WRITE))
            |-> result.last)
        else $error("multi-result sequence from a single-result outcome");

    // A reader batch drains one read grant per cycle with no gaps
    a_batch_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=>
            result_valid && result.grant_valid && result.grant_kind == rwla_pkg::KIND_READ)
        else $error("reader batch broken");

endmodule

bind reader_writer_lock_arbiter rwla_checker u_rwla_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result       (result)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for reader_writer_lock_arbiter: directed and random lock requests.
// Predicts grants with its own lock model; depends on rwla_pkg and the arbiter RTL.
module tb_top;

    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PER_SET = 35;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    rwla_pkg::cmd_t    cmd = '0;
    logic              busy;
    logic              result_valid;
    rwla_pkg::result_t result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data = '0;

    // Lock model state
    logic [7:0] readers_holding;
    logic       writer_holding;
    logic [7:0] parked_readers [rwla_pkg::READER_QUEUE_DEPTH];
    int         parked_reader_cnt;
    logic [7:0] parked_writers [rwla_pkg::WRITER_QUEUE_DEPTH];
    int         parked_writer_cnt;
    int         writer_head;
    logic [7:0] writer_run;
    logic [7:0] batch_limit;

    rwla_pkg::result_t expected_grants [$];
    rwla_pkg::result_t want;
    int                mismatch_cnt = 0;
    int                quiet_cycles = 0;
    bit                steady = 1'b0;

    reader_writer_lock_arbiter dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic push_grant(logic gv, logic kind, logic [7:0] id, logic [1:0] st);
        rwla_pkg::result_t r;
        r.grant_valid = gv;
        r.grant_kind  = kind;
        r.grant_id    = id;
        r.status      = st;
        r.last        = 1'b0;
        expected_grants.push_back(r);
    endtask

    task automatic hand_to_writer();
        logic [7:0] id;
        id = parked_writers[writer_head];
        writer_head = (writer_head + 1) % rwla_pkg::WRITER_QUEUE_DEPTH;
        parked_writer_cnt--;
        writer_holding = 1'b1;
        if (parked_reader_cnt > 0)
        begin
            if (writer_run != rwla_pkg::CNT_MAX)
                writer_run++;
        end
        else
        begin
            writer_run = '0;
        end
        push_grant(1'b1, rwla_pkg::KIND_WRITE, id, rwla_pkg::ST_DONE);
    endtask

    task automatic admit_reader_batch();
        for (int i = 0; i < parked_reader_cnt; i++)
        begin
            push_grant(1'b1, rwla_pkg::KIND_READ, parked_readers[i], rwla_pkg::ST_DONE);
            if (readers_holding != rwla_pkg::CNT_MAX)
                readers_holding++;
        end
        parked_reader_cnt = 0;
        writer_run = '0;
    endtask

    // Work out every result of one transferred request; runs without advancing time
    task automatic arbitrate(rwla_pkg::cmd_t c);
        int                before_cnt;
        rwla_pkg::result_t tail;
        before_cnt = expected_grants.size();
        case (c.operation)
            rwla_pkg::OP_RACQ:
            begin
                if (!writer_holding && parked_writer_cnt == 0)
                begin
                    if (readers_holding != rwla_pkg::CNT_MAX)
                    begin
                        readers_holding++;
                        push_grant(1'b1, rwla_pkg::KIND_READ, c.requester_id,
                                   rwla_pkg::ST_DONE);
                    end
                    else
                    begin
                        push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_FULL);
                    end
                end
                else if (parked_reader_cnt < rwla_pkg::READER_QUEUE_DEPTH)
                begin
                    parked_readers[parked_reader_cnt] = c.requester_id;
                    parked_reader_cnt++;
                    push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_QUEUED);
                end
                else
                begin
                    push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_FULL);
                end
            end
            rwla_pkg::OP_WACQ:
            begin
                if (readers_holding == 0 && !writer_holding && parked_writer_cnt == 0)
                begin
                    writer_holding = 1'b1;
                    if (parked_reader_cnt > 0)
                    begin
                        if (writer_run != rwla_pkg::CNT_MAX)
                            writer_run++;
                    end
                    else
                    begin
                        writer_run = '0;
                    end
                    push_grant(1'b1, rwla_pkg::KIND_WRITE, c.requester_id, rwla_pkg::ST_DONE);
                end
                else if (parked_writer_cnt < rwla_pkg::WRITER_QUEUE_DEPTH)
                begin
                    parked_writers[(writer_head + parked_writer_cnt) %
                                   rwla_pkg::WRITER_QUEUE_DEPTH] = c.requester_id;
                    parked_writer_cnt++;
                    push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_QUEUED);
                end
                else
                begin
                    push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_FULL);
                end
            end
            rwla_pkg::OP_RREL:
            begin
                if (readers_holding == 0)
                begin
                    push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_BAD_REL);
                end
                else
                begin
                    readers_holding--;
                    if (readers_holding == 0 && !writer_holding)
                    begin
                        if (parked_writer_cnt > 0)
                            hand_to_writer();
                        else if (parked_reader_cnt > 0)
                            admit_reader_batch();
                    end
                end
            end
            default:
            begin
                if (!writer_holding)
                begin
                    push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_BAD_REL);
                end
                else
                begin
                    writer_holding = 1'b0;
                    if (parked_reader_cnt > 0 &&
                        (writer_run >= batch_limit || parked_writer_cnt == 0))
                        admit_reader_batch();
                    else if (parked_writer_cnt > 0)
                        hand_to_writer();
                    else
                        writer_run = '0;
                end
            end
        endcase
        // A valid release that grants nobody still gets one plain acknowledge
        if (expected_grants.size() == before_cnt)
            push_grant(1'b0, rwla_pkg::KIND_READ, '0, rwla_pkg::ST_DONE);
        tail = expected_grants.pop_back();
        tail.last = 1'b1;
        expected_grants.push_back(tail);
    endtask

    task automatic report_mismatch(string what, rwla_pkg::result_t exp_r,
                                   rwla_pkg::result_t got_r);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
        begin
            $write("[%0t] %s: expected valid=%0d kind=%0d id=%02h st=%0d last=%0d",
                   $realtime, what, exp_r.grant_valid, exp_r.grant_kind, exp_r.grant_id,
                   exp_r.status, exp_r.last);
            $display(", got valid=%0d kind=%0d id=%02h st=%0d last=%0d",
                     got_r.grant_valid, got_r.grant_kind, got_r.grant_id,
                     got_r.status, got_r.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_grants.size() == 0)
            begin
                report_mismatch("unexpected result", '0, result);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (result.grant_valid !== want.grant_valid ||
                    result.grant_kind  !== want.grant_kind  ||
                    result.grant_id    !== want.grant_id    ||
                    result.status      !== want.status      ||
                    result.last        !== want.last)
                    report_mismatch("result mismatch", want, result);
            end
        end
    end

    // Count cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] op, logic [7:0] id);
        rwla_pkg::cmd_t c;
        c.operation    = op;
        c.requester_id = id;
        if (!steady && $urandom_range(0, 99) < 31)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        arbitrate(c);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_batch_limit(logic [7:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        batch_limit = value;
    endtask

    // Release whatever the model says is held until nothing holds or waits
    task automatic release_all();
        int guard;
        guard = 0;
        while ((readers_holding != 0 || writer_holding) && guard < 600)
        begin
            if (readers_holding != 0)
                send_request(rwla_pkg::OP_RREL, 8'($urandom));
            else
                send_request(rwla_pkg::OP_WREL, 8'($urandom));
            guard++;
        end
    endtask

    task automatic test_basic_handoff();
        send_request(rwla_pkg::OP_RREL, 8'h00);   // release with nothing held
        send_request(rwla_pkg::OP_WREL, 8'hFF);
        send_request(rwla_pkg::OP_RACQ, 8'h00);
        send_request(rwla_pkg::OP_RACQ, 8'hFF);
        send_request(rwla_pkg::OP_WACQ, 8'hA5);   // waits behind readers
        send_request(rwla_pkg::OP_RACQ, 8'h5A);   // waits behind the waiting writer
        send_request(rwla_pkg::OP_WREL, 8'h12);   // writer not holding
        send_request(rwla_pkg::OP_RREL, 8'h00);
        send_request(rwla_pkg::OP_RREL, 8'hFF);   // last reader hands over to the writer
        send_request(rwla_pkg::OP_WACQ, 8'h3C);
        send_request(rwla_pkg::OP_RACQ, 8'h81);
        send_request(rwla_pkg::OP_WREL, 8'hA5);   // next writer, below the batch limit
        send_request(rwla_pkg::OP_WREL, 8'h3C);   // no writer waits: reader batch
        send_request(rwla_pkg::OP_WACQ, 8'hC3);
        send_request(rwla_pkg::OP_RREL, 8'h5A);
        send_request(rwla_pkg::OP_RREL, 8'h81);
        send_request(rwla_pkg::OP_WREL, 8'hC3);   // nobody waits
        send_request(rwla_pkg::OP_WACQ, 8'h7E);
        send_request(rwla_pkg::OP_WREL, 8'h7E);
        send_request(rwla_pkg::OP_RREL, 8'h24);
    endtask

    // Fill both wait queues back to back, then drain them
    task automatic test_queue_full();
        steady = 1'b1;
        send_request(rwla_pkg::OP_WACQ, 8'($urandom));
        repeat (rwla_pkg::READER_QUEUE_DEPTH + 1)
            send_request(rwla_pkg::OP_RACQ, 8'($urandom));
        repeat (rwla_pkg::WRITER_QUEUE_DEPTH + 1)
            send_request(rwla_pkg::OP_WACQ, 8'($urandom));
        release_all();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [7:0] limits [6];
        int         p;
        logic [1:0] op;
        limits = '{8'd1, 8'd0, 8'd255, 8'd2, 8'($urandom_range(3, 254)),
                   rwla_pkg::LIMIT_RESET};
        foreach (limits[s])
        begin
            write_batch_limit(limits[s]);
            repeat (RANDOM_PER_SET)
            begin
                p = $urandom_range(0, 99);
                if (p < 8)
                    op = 2'($urandom);
                else if (p < 35)
                    op = rwla_pkg::OP_RACQ;
                else if (p < 58)
                    op = rwla_pkg::OP_WACQ;
                else if (readers_holding != 0 && (p < 80 || !writer_holding))
                    op = rwla_pkg::OP_RREL;
                else if (writer_holding)
                    op = rwla_pkg::OP_WREL;
                else
                    op = rwla_pkg::OP_WACQ;
                send_request(op, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        readers_holding   = '0;
        writer_holding    = 1'b0;
        parked_reader_cnt = 0;
        parked_writer_cnt = 0;
        writer_head       = 0;
        writer_run        = '0;
        batch_limit       = rwla_pkg::LIMIT_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_handoff();
        release_all();
        test_queue_full();
        test_random_traffic();
        release_all();

        wait_quiet();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && expected_grants.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ reader_writer_lock_arbiter.f @@
sv/rwla_pkg.sv
sv/rwla_front.sv
sv/rwla_back.sv
sv/reader_writer_lock_arbiter.sv
sv/rwla_checker.sv
dv/tb_top.sv
